### design/dsp_pkg.sv
`default_nettype none

package dsp_pkg;

    localparam logic [5:0]  VC_RESET = 6'd32;
    localparam logic [20:0] DIST_MAX = 21'h1FFFFF;
    localparam logic        CMD_WRITE = 1'b0;
    localparam logic        CMD_RUN   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] weight;
        logic        edge_present;
        logic [4:0]  source;
    } dsp_item_t;

    typedef struct packed {
        logic [4:0]  vertex;
        logic [20:0] distance;
        logic [4:0]  predecessor;
        logic        reachable;
        logic        last;
    } dsp_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELAX,
        ST_PICK,
        ST_OUT
    } dsp_state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic relax;
        logic pick;
        logic emit;
    } dsp_cmd_t;

    typedef struct packed {
        logic src_ok;
        logic scan_done;
        logic found;
        logic emit_last;
        logic out_free;
    } dsp_status_t;

endpackage

`default_nettype wire

### design/dense_shortest_path_engine.sv
`default_nettype none

// Matrix write: one item per cycle while idle, next item taken in the following cycle.
// Run with n vertices in use: the item is taken, then for each settled vertex its matrix
// row is read entry by entry and the next vertex picked; then n results, one per cycle
// while each is taken at once; the next item can be taken once the last is issued.
// rst_n (asynchronous, active low) clears control and sets vertex_count to 32;
// the edge matrix is undefined until written.
module dense_shortest_path_engine #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire dsp_pkg::dsp_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output dsp_pkg::dsp_result_t      result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [5:0]           cfg_data
);
    import dsp_pkg::*;

    dsp_cmd_t    cmd;
    dsp_status_t status;

    assign cfg_ready = 1'b1;

    dsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_command (item.command),
        .item_ready   (item_ready),
        .status       (status),
        .cmd          (cmd)
    );

    dsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

### design/dsp_ctrl.sv
`default_nettype none

module dsp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_command,
    output logic                     item_ready,
    input  wire dsp_pkg::dsp_status_t status,
    output dsp_pkg::dsp_cmd_t        cmd
);
    import dsp_pkg::*;

    dsp_state_t state_reg;
    dsp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_command == CMD_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.src_ok ? ST_RELAX : ST_OUT;
                    end
                end
            end
            ST_RELAX:
            begin
                cmd.relax = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (status.found)
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_RELAX;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/dsp_datapath.sv
`default_nettype none

module dsp_datapath #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dsp_pkg::dsp_item_t  item,
    input  wire logic                cfg_write,
    input  wire logic [5:0]          cfg_data,
    input  wire dsp_pkg::dsp_cmd_t   cmd,
    output dsp_pkg::dsp_status_t     status,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output dsp_pkg::dsp_result_t     result
);
    import dsp_pkg::*;

    localparam int USED  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int IW    = $clog2(USED);
    localparam int CW    = $clog2(USED + 1);
    localparam int EW    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int DEPTH = 1 << (2 * IW);

    logic [EW:0]       edge_mem [DEPTH];
    logic [EW:0]       mem_q_reg;

    logic [5:0]        vc_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     n_eff;

    logic [20:0]       dist_reg   [USED];
    logic [IW-1:0]     pred_reg   [USED];
    logic [USED-1:0]   fin_reg;
    logic [USED-1:0]   finite_reg;

    logic [IW-1:0]     u_reg;
    logic [20:0]       du_reg;
    logic [CW-1:0]     issue_reg;
    logic              stage_valid_reg;
    logic [IW-1:0]     stage_idx_reg;
    logic              found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [20:0]       best_d_reg;
    logic [IW-1:0]     out_cnt_reg;
    logic              result_valid_reg;
    dsp_result_t       result_reg;

    logic              wr_ok;
    logic              rd_en;
    logic [IW-1:0]     src_idx;
    logic [21:0]       sum_raw;
    logic [20:0]       sum_sat;
    logic              edge_on;
    logic              upd;
    logic [20:0]       new_d;
    logic              new_f;
    logic              cand;

    always_comb
    begin
        if (vc_reg == 6'd0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(vc_reg) > USED)
        begin
            n_eff = CW'(USED);
        end
        else
        begin
            n_eff = CW'(vc_reg);
        end
    end

    assign wr_ok   = (32'(item.row) < MAX_VERTICES) && (32'(item.col) < MAX_VERTICES);
    assign rd_en   = cmd.relax && (issue_reg < n_reg);
    assign src_idx = item.source[IW-1:0];

    assign edge_on = mem_q_reg[EW];
    assign sum_raw = {1'b0, du_reg} + 22'(mem_q_reg[EW-1:0]);
    assign sum_sat = sum_raw[21] ? DIST_MAX : sum_raw[20:0];
    assign upd     = stage_valid_reg && edge_on &&
                     (!finite_reg[stage_idx_reg] || (dist_reg[stage_idx_reg] > sum_sat));
    assign new_d   = upd ? sum_sat : dist_reg[stage_idx_reg];
    assign new_f   = upd || finite_reg[stage_idx_reg];
    assign cand    = stage_valid_reg && !fin_reg[stage_idx_reg] && new_f &&
                     (!found_reg || (new_d < best_d_reg));

    assign status.src_ok    = 32'(item.source) < 32'(n_eff);
    assign status.scan_done = stage_valid_reg && ((CW'(stage_idx_reg) + CW'(1)) == n_reg);
    assign status.found     = found_reg;
    assign status.emit_last = (CW'(out_cnt_reg) + CW'(1)) == n_reg;
    assign status.out_free  = !result_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            edge_mem[{item.row[IW-1:0], item.col[IW-1:0]}] <=
                {item.edge_present, item.weight[EW-1:0]};
        end
        if (rd_en)
        begin
            mem_q_reg <= edge_mem[{u_reg, issue_reg[IW-1:0]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg           <= VC_RESET;
            n_reg            <= CW'(1);
            fin_reg          <= '0;
            finite_reg       <= '0;
            issue_reg        <= '0;
            stage_valid_reg  <= 1'b0;
            found_reg        <= 1'b0;
            out_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                vc_reg <= cfg_data;
            end
            stage_valid_reg <= rd_en;
            if (rd_en)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (cand)
            begin
                found_reg <= 1'b1;
            end
            if (upd)
            begin
                finite_reg[stage_idx_reg] <= 1'b1;
            end
            if (cmd.start)
            begin
                n_reg       <= n_eff;
                issue_reg   <= '0;
                found_reg   <= 1'b0;
                out_cnt_reg <= '0;
                fin_reg     <= '0;
                finite_reg  <= '0;
                if (status.src_ok)
                begin
                    fin_reg[src_idx]    <= 1'b1;
                    finite_reg[src_idx] <= 1'b1;
                end
            end
            if (cmd.pick)
            begin
                issue_reg              <= '0;
                found_reg              <= 1'b0;
                fin_reg[best_idx_reg]  <= 1'b1;
            end
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
                out_cnt_reg      <= out_cnt_reg + IW'(1);
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_idx_reg <= issue_reg[IW-1:0];
        if (upd)
        begin
            dist_reg[stage_idx_reg] <= sum_sat;
            pred_reg[stage_idx_reg] <= u_reg;
        end
        if (cand)
        begin
            best_idx_reg <= stage_idx_reg;
            best_d_reg   <= new_d;
        end
        if (cmd.start)
        begin
            for (int i = 0; i < USED; i++)
            begin
                dist_reg[i] <= DIST_MAX;
                pred_reg[i] <= '0;
            end
            u_reg  <= src_idx;
            du_reg <= '0;
            if (status.src_ok)
            begin
                dist_reg[src_idx] <= '0;
                pred_reg[src_idx] <= src_idx;
            end
        end
        if (cmd.pick)
        begin
            u_reg  <= best_idx_reg;
            du_reg <= best_d_reg;
        end
        if (cmd.emit)
        begin
            result_reg.vertex      <= 5'(out_cnt_reg);
            result_reg.distance    <= finite_reg[out_cnt_reg] ? dist_reg[out_cnt_reg] : '0;
            result_reg.predecessor <= finite_reg[out_cnt_reg] ? 5'(pred_reg[out_cnt_reg]) : '0;
            result_reg.reachable   <= finite_reg[out_cnt_reg];
            result_reg.last        <= status.emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### tb/dense_shortest_path_engine_tb.sv
`default_nettype none

module dense_shortest_path_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsp_pkg::*;

    localparam int NV          = 32;
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int ITEM_GOAL   = 280;

    typedef enum int {
        TAKE_ALL,
        TAKE_MOST,
        TAKE_FEW,
        TAKE_THIRD
    } take_mode_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    dsp_item_t   item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    dsp_result_t result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data     = '0;

    bit   [16:0] edge_store  [NV][NV];
    bit          entry_set   [NV][NV];
    logic [5:0]  vertex_count_q = VC_RESET;
    int unsigned path_cost   [NV];
    logic [4:0]  path_prev   [NV];
    bit          path_found  [NV];

    dsp_result_t path_reports_due [$];
    int          bad_reports   = 0;
    int          quiet_cycles  = 0;
    int          burst_left    = 0;
    int          items_sent    = 0;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    take_mode_t  take_mode     = TAKE_ALL;

    dense_shortest_path_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int active_vertices();
        if (int'(vertex_count_q) == 0)
            return 1;
        if (int'(vertex_count_q) > NV)
            return NV;
        return int'(vertex_count_q);
    endfunction

    function automatic void solve_paths(input logic [4:0] src);
        int          n;
        int          u;
        int          v;
        bit          settled [NV];
        bit          picked;
        int unsigned total;
        n = active_vertices();
        for (v = 0; v < NV; v++)
        begin
            path_cost[v]  = 32'(DIST_MAX);
            path_prev[v]  = '0;
            path_found[v] = 1'b0;
            settled[v]    = 1'b0;
        end
        if (int'(src) >= n)
            return;
        path_cost[src]  = 0;
        path_prev[src]  = src;
        path_found[src] = 1'b1;
        forever
        begin
            picked = 1'b0;
            u = 0;
            for (v = 0; v < n; v++)
                if (!settled[v] && path_found[v] && (!picked || path_cost[v] < path_cost[u]))
                begin
                    u = v;
                    picked = 1'b1;
                end
            if (!picked)
                break;
            settled[u] = 1'b1;
            for (v = 0; v < n; v++)
            begin
                if (!edge_store[u][v][16])
                    continue;
                total = path_cost[u] + 32'(edge_store[u][v][15:0]);
                if (total > 32'(DIST_MAX))
                    total = 32'(DIST_MAX);
                if (!path_found[v] || path_cost[v] > total)
                begin
                    path_cost[v]  = total;
                    path_prev[v]  = u[4:0];
                    path_found[v] = 1'b1;
                end
            end
        end
    endfunction

    function automatic void predict_item(input dsp_item_t it);
        int          n;
        int          v;
        dsp_result_t r;
        if (it.command == CMD_WRITE)
        begin
            edge_store[it.row][it.col] = {it.edge_present, it.weight};
            entry_set[it.row][it.col]  = 1'b1;
            return;
        end
        solve_paths(it.source);
        n = active_vertices();
        for (v = 0; v < n; v++)
        begin
            r.vertex      = v[4:0];
            r.reachable   = path_found[v];
            r.distance    = path_found[v] ? 21'(path_cost[v]) : '0;
            r.predecessor = path_found[v] ? path_prev[v] : '0;
            r.last        = (v == n - 1);
            path_reports_due.push_back(r);
        end
    endfunction

    function automatic dsp_item_t random_item();
        dsp_item_t it;
        it.command      = 1'($urandom_range(0, 1));
        it.row          = 5'($urandom);
        it.col          = 5'($urandom);
        it.weight       = 16'($urandom);
        it.edge_present = 1'($urandom_range(0, 1));
        it.source       = 5'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input dsp_item_t it);
        if (burst_left == 0)
        begin
            if (item_valid)
                item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        items_sent++;
        predict_item(it);
        @(negedge clk);
    endtask

    task automatic write_entry(input int r, input int c, input bit present,
                               input logic [15:0] w);
        dsp_item_t it;
        it              = random_item();
        it.command      = CMD_WRITE;
        it.row          = r[4:0];
        it.col          = c[4:0];
        it.edge_present = present;
        it.weight       = w;
        send_item(it);
    endtask

    // fill every entry the run will read before issuing it
    task automatic run_from(input logic [4:0] src);
        dsp_item_t it;
        bit        filled;
        int        n;
        int        u;
        int        v;
        n = active_vertices();
        do
        begin
            filled = 1'b0;
            solve_paths(src);
            for (u = 0; u < n; u++)
                if (path_found[u])
                    for (v = 0; v < n; v++)
                        if (!entry_set[u][v])
                        begin
                            filled = 1'b1;
                            write_entry(u, v, $urandom_range(0, 2 * n) == 0, 16'($urandom));
                        end
        end
        while (filled);
        it         = random_item();
        it.command = CMD_RUN;
        it.source  = src;
        send_item(it);
    endtask

    task automatic settle();
        if (item_valid)
            item_valid <= 1'b0;
        while (path_reports_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_vertex_count(input logic [5:0] count);
        settle();
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        vertex_count_q = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_full_width_at_reset();
        run_from(5'd0);
        run_from(5'd31);
    endtask

    task automatic test_small_graph();
        set_vertex_count(6'd4);
        write_entry(0, 1, 1'b1, 16'd5);
        write_entry(0, 2, 1'b1, 16'd5);
        write_entry(1, 3, 1'b1, 16'd0);
        write_entry(2, 3, 1'b1, 16'd0);
        write_entry(1, 1, 1'b1, 16'd0);
        write_entry(3, 0, 1'b1, 16'd1);
        write_entry(2, 1, 1'b1, 16'hFFFF);
        write_entry(0, 3, 1'b1, 16'hFFFF);
        write_entry(0, 3, 1'b0, 16'hFFFF);
        run_from(5'd0);
        run_from(5'd2);
        run_from(5'd3);
        run_from(5'd4);
        run_from(5'd31);
    endtask

    task automatic test_count_extremes();
        set_vertex_count(6'd0);
        run_from(5'd0);
        run_from(5'd1);
        set_vertex_count(6'd63);
        run_from(5'd7);
        set_vertex_count(6'd33);
        run_from(5'd31);
        set_vertex_count(6'd1);
        run_from(5'd0);
    endtask

    task automatic test_output_stall();
        int k;
        set_vertex_count(6'd8);
        run_from(5'd0);
        settle();
        hold_request = 1'b1;
        burst_left   = 12;
        run_from(5'd0);
        for (k = 0; k < 6; k++)
            write_entry($urandom_range(0, 7), $urandom_range(0, 7), 1'b1, pick_weight());
    endtask

    task automatic test_random_traffic();
        int         n;
        int         pick;
        logic [5:0] count;
        while (items_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0:       count = 6'($urandom_range(0, 1));
                1:       count = 6'($urandom_range(9, 63));
                default: count = 6'($urandom_range(2, 8));
            endcase
            set_vertex_count(count);
            n = active_vertices();
            repeat ($urandom_range(10, 40))
            begin
                if (items_sent >= ITEM_GOAL)
                    break;
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    write_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                n > 8 ? $urandom_range(0, 3) == 0 : $urandom_range(0, 3) != 0,
                                pick_weight());
                else if (pick == 6)
                    write_entry($urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                                1'($urandom_range(0, 1)), pick_weight());
                else if (pick <= 8)
                    run_from(5'($urandom_range(0, n - 1)));
                else
                    run_from(5'($urandom_range(0, NV - 1)));
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                take_mode = take_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (take_mode)
                TAKE_ALL:   result_ready <= 1'b1;
                TAKE_MOST:  result_ready <= ($urandom_range(0, 3) != 0);
                TAKE_FEW:   result_ready <= ($urandom_range(0, 3) == 0);
                default:    result_ready <= (mode_left % 3 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        dsp_result_t want;
        if (result_valid && result_ready)
        begin
            if (path_reports_due.size() == 0)
            begin
                bad_reports++;
                if (bad_reports <= 10)
                    $display("unexpected path report: v=%0d d=%0d p=%0d r=%0b l=%0b",
                             result.vertex, result.distance, result.predecessor,
                             result.reachable, result.last);
            end
            else
            begin
                want = path_reports_due.pop_front();
                if (result.vertex !== want.vertex || result.distance !== want.distance ||
                    result.predecessor !== want.predecessor ||
                    result.reachable !== want.reachable || result.last !== want.last)
                begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display("path report mismatch: expected v=%0d d=%0d p=%0d r=%0b l=%0b%s",
                                 want.vertex, want.distance, want.predecessor,
                                 want.reachable, want.last, "");
                    if (bad_reports <= 10)
                        $display("                      got      v=%0d d=%0d p=%0d r=%0b l=%0b",
                                 result.vertex, result.distance, result.predecessor,
                                 result.reachable, result.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_full_width_at_reset();
        test_small_graph();
        test_count_extremes();
        test_output_stall();
        test_random_traffic();
        settle();
        repeat (40) @(negedge clk);
        bad_reports += path_reports_due.size();
        if (bad_reports == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
